// ===== design/tksd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tksd_pkg;

    // Sizing defaults
    localparam int SEQ_BUFFER_SIZE_DEF = 16;
    localparam int PADDR_W             = 3;
    localparam int PDATA_W             = 32;

    // Register map (word index taken from paddr[2])
    localparam logic ADDR_GAP_LIMIT = 1'b0;

    localparam logic [3:0] GAP_LIMIT_RESET = 4'd9;

    // Input kinds carried on s_tuser
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_GAP  = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_ESC    = 8'h1b;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_SS3    = 8'h4f;
    localparam logic [7:0] CH_TILDE  = 8'h7e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Doorway scancodes
    localparam logic [7:0] SC_F1    = 8'h3b;
    localparam logic [7:0] SC_F10   = 8'h44;
    localparam logic [7:0] SC_HOME  = 8'h47;
    localparam logic [7:0] SC_UP    = 8'h48;
    localparam logic [7:0] SC_PGUP  = 8'h49;
    localparam logic [7:0] SC_LEFT  = 8'h4b;
    localparam logic [7:0] SC_RIGHT = 8'h4d;
    localparam logic [7:0] SC_END   = 8'h4f;
    localparam logic [7:0] SC_DOWN  = 8'h50;
    localparam logic [7:0] SC_PGDN  = 8'h51;
    localparam logic [7:0] SC_INS   = 8'h52;
    localparam logic [7:0] SC_DEL   = 8'h53;

    // Named key codes
    localparam logic [7:0] K_UP      = 8'd0;
    localparam logic [7:0] K_DOWN    = 8'd1;
    localparam logic [7:0] K_LEFT    = 8'd2;
    localparam logic [7:0] K_RIGHT   = 8'd3;
    localparam logic [7:0] K_HOME    = 8'd4;
    localparam logic [7:0] K_END     = 8'd5;
    localparam logic [7:0] K_PGUP    = 8'd6;
    localparam logic [7:0] K_PGDN    = 8'd7;
    localparam logic [7:0] K_INS     = 8'd8;
    localparam logic [7:0] K_DEL     = 8'd9;
    localparam logic [7:0] K_F1      = 8'd10;
    localparam logic [7:0] K_F5      = 8'd14;
    localparam logic [7:0] K_F6      = 8'd15;
    localparam logic [7:0] K_F7      = 8'd16;
    localparam logic [7:0] K_F8      = 8'd17;
    localparam logic [7:0] K_F9      = 8'd18;
    localparam logic [7:0] K_F10     = 8'd19;
    localparam logic [7:0] K_F11     = 8'd20;
    localparam logic [7:0] K_F12     = 8'd21;
    localparam logic [7:0] K_UNKNOWN = 8'd22;

    // One decoded key
    typedef struct packed {
        logic       named;
        logic [7:0] value;
    } key_res_t;

    // Decode a finished escape sequence
    function automatic logic [7:0] decode_seq(
        input logic [7:0] first,
        input logic [7:0] second,
        input logic [7:0] last,
        input logic [7:0] digit
    );
        logic [7:0] k;
        k = K_UNKNOWN;
        if (first == CH_LBRACK) begin
            unique case (second)
                "A":     k = K_UP;
                "B":     k = K_DOWN;
                "C":     k = K_RIGHT;
                "D":     k = K_LEFT;
                "H":     k = K_HOME;
                "F":     k = K_END;
                "K":     k = K_END;
                "U":     k = K_PGUP;
                "V":     k = K_PGDN;
                "@":     k = K_INS;
                default:
                begin
                    if (last == CH_TILDE) begin
                        unique case (digit)
                            8'd2:    k = K_INS;
                            8'd3:    k = K_DEL;
                            8'd5:    k = K_PGUP;
                            8'd6:    k = K_PGDN;
                            8'd15:   k = K_F5;
                            8'd17:   k = K_F6;
                            8'd18:   k = K_F7;
                            8'd19:   k = K_F8;
                            8'd20:   k = K_F9;
                            8'd21:   k = K_F10;
                            8'd23:   k = K_F11;
                            8'd24:   k = K_F12;
                            default: k = K_UNKNOWN;
                        endcase
                    end
                end
            endcase
        end
        else if (first == CH_SS3) begin
            unique case (second)
                "P":     k = K_F1;
                "Q":     k = K_F1 + 8'd1;
                "R":     k = K_F1 + 8'd2;
                "S":     k = K_F1 + 8'd3;
                "t":     k = K_F5;
                default: k = K_UNKNOWN;
            endcase
        end
        return k;
    endfunction

    // Decode the byte that follows a doorway 0x00; unknown gives plain 0x00
    function automatic key_res_t decode_scancode(input logic [7:0] b);
        key_res_t r;
        r.named = 1'b1;
        r.value = K_UNKNOWN;
        if (b >= SC_F1 && b <= SC_F10) begin
            r.value = K_F1 + (b - SC_F1);
        end
        else begin
            unique case (b)
                SC_DOWN:  r.value = K_DOWN;
                SC_UP:    r.value = K_UP;
                SC_LEFT:  r.value = K_LEFT;
                SC_RIGHT: r.value = K_RIGHT;
                SC_HOME:  r.value = K_HOME;
                SC_END:   r.value = K_END;
                SC_PGUP:  r.value = K_PGUP;
                SC_PGDN:  r.value = K_PGDN;
                SC_INS:   r.value = K_INS;
                SC_DEL:   r.value = K_DEL;
                default:
                begin
                    r.named = 1'b0;
                    r.value = CH_NUL;
                end
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tksd_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Key decode state machine: one item per step, result given combinationally
module tksd_decoder #(
    parameter int SEQ_BUFFER_SIZE = tksd_pkg::SEQ_BUFFER_SIZE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              gap,
    input  wire logic [7:0]        rx_byte,
    input  wire logic [3:0]        gap_limit,
    output tksd_pkg::key_res_t     res,
    output logic                   res_valid
);

    localparam int SEQ_LEN_W = $clog2(SEQ_BUFFER_SIZE);
    localparam logic [SEQ_LEN_W-1:0] SEQ_FULL = SEQ_LEN_W'(SEQ_BUFFER_SIZE - 1);

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC_WAIT,
        MODE_ESC_SEQ,
        MODE_DOORWAY
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic                 after_cr_reg, after_cr_next;
    logic [3:0]           gap_count_reg, gap_count_next;
    logic [SEQ_LEN_W-1:0] seq_len_reg, seq_len_next;
    logic [7:0]           first_reg, first_next;
    logic [7:0]           second_reg, second_next;
    logic [7:0]           last_reg, last_next;
    logic [7:0]           digit_reg, digit_next;
    logic                 ended_reg, ended_next;

    // Sequence fields as they would be after storing this byte
    logic [SEQ_LEN_W-1:0] st_len;
    logic [7:0]           st_first, st_second, st_last, st_digit;
    logic                 st_ended;
    logic                 is_digit;
    logic [11:0]          digit_ext, digit_sum;
    logic [3:0]           gap_inc;

    always_comb
    begin
        is_digit  = (rx_byte >= tksd_pkg::CH_ZERO) && (rx_byte <= tksd_pkg::CH_NINE);
        digit_ext = {4'd0, digit_reg};
        digit_sum = (digit_ext << 3) + (digit_ext << 1) + {8'd0, rx_byte[3:0]};

        st_first  = first_reg;
        st_second = second_reg;
        st_digit  = digit_reg;
        st_ended  = ended_reg;
        st_last   = rx_byte;
        st_len    = seq_len_reg + SEQ_LEN_W'(1);
        if (seq_len_reg == '0) begin
            st_first = rx_byte;
        end
        else begin
            if (seq_len_reg == SEQ_LEN_W'(1)) begin
                st_second = rx_byte;
            end
            if (!ended_reg) begin
                if (is_digit) begin
                    st_digit = (digit_sum > 12'd255) ? 8'd255 : digit_sum[7:0];
                end
                else begin
                    st_ended = 1'b1;
                end
            end
        end
    end

    // Next state and result
    always_comb
    begin
        mode_next      = mode_reg;
        after_cr_next  = after_cr_reg;
        gap_count_next = gap_count_reg;
        seq_len_next   = seq_len_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        last_next      = last_reg;
        digit_next     = digit_reg;
        ended_next     = ended_reg;
        res_valid      = 1'b0;
        res            = '0;
        gap_inc        = gap_count_reg + 4'd1;

        unique case (mode_reg)
            MODE_ESC_WAIT,
            MODE_ESC_SEQ:
            begin
                if (gap) begin
                    mode_next = MODE_IDLE;
                    res_valid = 1'b1;
                    if (mode_reg == MODE_ESC_WAIT) begin
                        res.named = 1'b0;
                        res.value = tksd_pkg::CH_ESC;
                    end
                    else begin
                        res.named = 1'b1;
                        res.value = tksd_pkg::decode_seq(first_reg, second_reg,
                                                         last_reg, digit_reg);
                    end
                end
                else if (mode_reg == MODE_ESC_SEQ && rx_byte == tksd_pkg::CH_ESC) begin
                    // New ESC ends this sequence and opens the next one
                    res_valid    = 1'b1;
                    res.named    = 1'b1;
                    res.value    = tksd_pkg::decode_seq(first_reg, second_reg,
                                                        last_reg, digit_reg);
                    mode_next    = MODE_ESC_WAIT;
                    seq_len_next = '0;
                    first_next   = '0;
                    second_next  = '0;
                    last_next    = '0;
                    digit_next   = '0;
                    ended_next   = 1'b0;
                end
                else begin
                    mode_next    = MODE_ESC_SEQ;
                    seq_len_next = st_len;
                    first_next   = st_first;
                    second_next  = st_second;
                    last_next    = st_last;
                    digit_next   = st_digit;
                    ended_next   = st_ended;
                    if (st_len >= SEQ_FULL) begin
                        mode_next = MODE_IDLE;
                        res_valid = 1'b1;
                        res.named = 1'b1;
                        res.value = tksd_pkg::decode_seq(st_first, st_second,
                                                         st_last, st_digit);
                    end
                end
            end

            MODE_DOORWAY:
            begin
                if (gap) begin
                    if (gap_inc >= gap_limit) begin
                        mode_next      = MODE_IDLE;
                        gap_count_next = '0;
                        res_valid      = 1'b1;
                        res.named      = 1'b0;
                        res.value      = tksd_pkg::CH_NUL;
                    end
                    else begin
                        gap_count_next = gap_inc;
                    end
                end
                else begin
                    mode_next      = MODE_IDLE;
                    gap_count_next = '0;
                    res_valid      = 1'b1;
                    res            = tksd_pkg::decode_scancode(rx_byte);
                end
            end

            MODE_IDLE:
            begin
                // After CR, one following NUL, LF or gap is swallowed
                if (after_cr_reg) begin
                    after_cr_next = 1'b0;
                end
                if (!gap && !(after_cr_reg && (rx_byte == tksd_pkg::CH_NUL ||
                                               rx_byte == tksd_pkg::CH_LF))) begin
                    if (rx_byte == tksd_pkg::CH_NUL) begin
                        mode_next      = MODE_DOORWAY;
                        gap_count_next = '0;
                    end
                    else if (rx_byte == tksd_pkg::CH_ESC) begin
                        mode_next    = MODE_ESC_WAIT;
                        seq_len_next = '0;
                        first_next   = '0;
                        second_next  = '0;
                        last_next    = '0;
                        digit_next   = '0;
                        ended_next   = 1'b0;
                    end
                    else begin
                        if (rx_byte == tksd_pkg::CH_CR) begin
                            after_cr_next = 1'b1;
                        end
                        res_valid = 1'b1;
                        res.named = 1'b0;
                        res.value = rx_byte;
                    end
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    // State registers, advanced once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_IDLE;
            after_cr_reg  <= 1'b0;
            gap_count_reg <= '0;
            seq_len_reg   <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            last_reg      <= '0;
            digit_reg     <= '0;
            ended_reg     <= 1'b0;
        end
        else if (step) begin
            mode_reg      <= mode_next;
            after_cr_reg  <= after_cr_next;
            gap_count_reg <= gap_count_next;
            seq_len_reg   <= seq_len_next;
            first_reg     <= first_next;
            second_reg    <= second_next;
            last_reg      <= last_next;
            digit_reg     <= digit_next;
            ended_reg     <= ended_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/terminal_key_sequence_decoder.sv =====
// Channel  | Signals                              | Contents
// ---------+--------------------------------------+------------------------------------
// s (in)   | s_tvalid s_tready s_tdata s_tuser    | tdata: rx_byte; tuser: opcode
// m (out)  | m_tvalid m_tready m_tdata m_tuser    | tdata: key_value; tuser: is_named
// apb      | psel penable pwrite paddr pwdata ... | 0x0: doorway_gap_limit [3:0]
//
// Each item passes through the input register and its result through the result
// register; one item per cycle is sustained while m_tready is high or no result is held.
// An item yields zero or one result; m_tvalid is driven by the result register.
// rst_n is asynchronous; the gap limit returns to 9 and the decoder to idle.
// s_tready drops only while both registers are full and m_tready is low.
`timescale 1ns / 1ps
`default_nettype none

module terminal_key_sequence_decoder #(
    parameter int SEQ_BUFFER_SIZE = tksd_pkg::SEQ_BUFFER_SIZE_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Input items
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  wire logic                           s_tuser,   // [0] opcode
    // Result items
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [7:0] key_value
    output logic                                m_tuser,   // [0] is_named
    // Configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tksd_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tksd_pkg::PDATA_W-1:0]   pwdata,
    output logic [tksd_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    logic               in_valid_reg;
    logic               in_gap_reg;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic               out_named_reg;
    logic [7:0]         out_value_reg;
    logic [3:0]         gap_limit_reg;
    logic               advance;
    logic               res_valid;
    tksd_pkg::key_res_t res;

    // Pipeline control
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end
        else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid) begin
            in_gap_reg  <= (s_tuser == tksd_pkg::OP_GAP);
            in_byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            out_named_reg <= res.named;
            out_value_reg <= res.value;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_named_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            gap_limit_reg <= tksd_pkg::GAP_LIMIT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == tksd_pkg::ADDR_GAP_LIMIT) begin
            gap_limit_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == tksd_pkg::ADDR_GAP_LIMIT)
                    ? {{(tksd_pkg::PDATA_W-4){1'b0}}, gap_limit_reg}
                    : '0;

    tksd_decoder #(
        .SEQ_BUFFER_SIZE (SEQ_BUFFER_SIZE)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .gap       (in_gap_reg),
        .rx_byte   (in_byte_reg),
        .gap_limit (gap_limit_reg),
        .res       (res),
        .res_valid (res_valid)
    );

endmodule

`default_nettype wire

// ===== design/tksd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tksd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [7:0]                    m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          psel,
    input wire logic                          penable,
    input wire logic                          pwrite,
    input wire logic [tksd_pkg::PADDR_W-1:0]  paddr,
    input wire logic [tksd_pkg::PDATA_W-1:0]  pwdata,
    input wire logic [tksd_pkg::PDATA_W-1:0]  prdata,
    input wire logic                          pready
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // Named keys stay within the key code range
    a_named_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata <= tksd_pkg::K_UNKNOWN)
        else $error("named key code out of range");

    // Input stalls only under output backpressure
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output backpressure");

    // Gap limit reads back what was written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr[2] == tksd_pkg::ADDR_GAP_LIMIT
        |=> paddr[2] != tksd_pkg::ADDR_GAP_LIMIT || prdata[3:0] == $past(pwdata[3:0]))
        else $error("gap limit readback mismatch");

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);

`default_nettype wire
